// ===== rtl/mss_pkg.sv =====
`timescale 1ns / 1ps

package mss_pkg;

   // Field widths of the item channels
   localparam int CH_W      = 3;
   localparam int SAMPLE_W  = 16;
   localparam int STAMP_W   = 63;
   localparam int SMALL_W   = 17;
   localparam int MEAN_W    = 24;
   localparam int ENERGY_W  = 48;
   localparam int COUNT_W   = 40;
   localparam int TIME_W    = 64;
   localparam int SUM_W     = 48;

   // Channel kind flags: five bits per channel, five channels in the register
   localparam int KIND_W      = 5;
   localparam int KIND_GROUPS = 5;
   localparam int KINDS_W     = KIND_W * KIND_GROUPS;

   localparam logic [KIND_W-1:0] KIND_ENERGY = 5'h01;
   localparam logic [KIND_W-1:0] KIND_MEAN   = 5'h04;
   localparam logic [KIND_W-1:0] KIND_STAMP  = 5'h10;

   // Smallest-magnitude store before any sample
   localparam logic [SMALL_W-1:0] MIN_RESET = 17'h0FFFF;

   // Mean divider: |sum| scaled by 256
   localparam int DIVIDEND_W = SUM_W + 8;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 64;
   localparam logic [CSR_INDEX_W-1:0] REG_CHANNEL_KINDS  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DURATION_LIMIT = 2'd1;

   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_UPDATE   = 5'b00010,
      ST_DIV_LOAD = 5'b00100,
      ST_DIV_RUN  = 5'b01000,
      ST_OUTPUT   = 5'b10000
   } mss_state_type;

   typedef struct packed {
      logic take_item;
      logic update;
      logic div_start;
      logic write_mean;
      logic load_out;
   } mss_cmd_type;

   typedef struct packed {
      logic mean_due;
      logic div_done;
   } mss_status_type;

   // Flag group of one channel; channels past the register have no flags
   function automatic logic [KIND_W-1:0] kinds_of(input logic [KINDS_W-1:0] kinds,
                                                  input logic [CH_W-1:0] ch);
      logic [KIND_W-1:0] res;
      case (ch)
         3'd0:    res = kinds[0*KIND_W +: KIND_W];
         3'd1:    res = kinds[1*KIND_W +: KIND_W];
         3'd2:    res = kinds[2*KIND_W +: KIND_W];
         3'd3:    res = kinds[3*KIND_W +: KIND_W];
         3'd4:    res = kinds[4*KIND_W +: KIND_W];
         default: res = '0;
      endcase
      return res;
   endfunction

endpackage

// ===== rtl/mss_ifs.sv =====
`timescale 1ns / 1ps

interface mss_req_if;
   logic                                valid;
   logic                                ready;
   logic [mss_pkg::CH_W-1:0]            channel;
   logic signed [mss_pkg::SAMPLE_W-1:0] sample_value;
   logic [mss_pkg::STAMP_W-1:0]         stamp;

   modport source (output valid, output channel, output sample_value, output stamp,
                   input ready);
   modport sink   (input valid, input channel, input sample_value, input stamp,
                   output ready);
endinterface

interface mss_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [mss_pkg::CH_W-1:0]            out_channel;
   logic signed [mss_pkg::SMALL_W-1:0]  smallest;
   logic signed [mss_pkg::SAMPLE_W-1:0] largest;
   logic signed [mss_pkg::MEAN_W-1:0]   mean_q8;
   logic [mss_pkg::ENERGY_W-1:0]        energy_sum;
   logic [mss_pkg::COUNT_W-1:0]         sample_count;
   logic signed [mss_pkg::TIME_W-1:0]   elapsed;
   logic                                limit_reached;

   modport source (output valid, output out_channel, output smallest, output largest,
                   output mean_q8, output energy_sum, output sample_count,
                   output elapsed, output limit_reached, input ready);
   modport sink   (input valid, input out_channel, input smallest, input largest,
                   input mean_q8, input energy_sum, input sample_count,
                   input elapsed, input limit_reached, output ready);
endinterface

interface mss_csr_if;
   logic                               valid;
   logic                               ready;
   logic [mss_pkg::CSR_INDEX_W-1:0]    index;
   logic [mss_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/mss_div.sv =====
`timescale 1ns / 1ps

module mss_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [mss_pkg::DIVIDEND_W-1:0]     dividend,
   input  logic [mss_pkg::COUNT_W-1:0]        divisor,
   output logic [mss_pkg::DIVIDEND_W-1:0]     quotient,
   output logic                               done
);

   localparam int N_W    = mss_pkg::DIVIDEND_W;
   localparam int D_W    = mss_pkg::COUNT_W;
   localparam int STEP_W = $clog2(N_W);

   logic [N_W-1:0]    work_ff, work_in;
   logic [D_W-1:0]    rem_ff, rem_in;
   logic [D_W-1:0]    div_ff;
   logic [STEP_W-1:0] step_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [D_W:0]      trial;
   logic [D_W:0]      diff;
   logic              fits;

   // One restoring step: bring down the next dividend bit, subtract if it fits
   always_comb begin
      trial   = {rem_ff, work_ff[N_W-1]};
      diff    = trial - {1'b0, div_ff};
      fits    = (trial >= {1'b0, div_ff});
      rem_in  = fits ? diff[D_W-1:0] : trial[D_W-1:0];
      work_in = {work_ff[N_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else if (busy_ff) begin
         step_ff <= step_ff + 1'b1;
         if (step_ff == STEP_W'(N_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   // Operand and partial remainder registers
   always_ff @(posedge clock) begin
      if (start) begin
         work_ff <= dividend;
         rem_ff  <= '0;
         div_ff  <= divisor;
      end else if (busy_ff) begin
         work_ff <= work_in;
         rem_ff  <= rem_in;
      end
   end

   assign quotient = work_ff;
   assign done     = done_ff;

   // A new division never starts over one in flight
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

endmodule

// ===== rtl/mss_ctrl.sv =====
`timescale 1ns / 1ps

module mss_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  mss_pkg::mss_status_type status,
   output mss_pkg::mss_cmd_type    cmd
);

   mss_pkg::mss_state_type state_ff, state_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Sequence one item: update, optional mean division, hand over the result
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         mss_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.take_item = 1'b1;
               state_in      = mss_pkg::ST_UPDATE;
            end
         end
         mss_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = status.mean_due ? mss_pkg::ST_DIV_LOAD : mss_pkg::ST_OUTPUT;
         end
         mss_pkg::ST_DIV_LOAD: begin
            cmd.div_start = 1'b1;
            state_in      = mss_pkg::ST_DIV_RUN;
         end
         mss_pkg::ST_DIV_RUN: begin
            if (status.div_done) begin
               cmd.write_mean = 1'b1;
               state_in       = mss_pkg::ST_OUTPUT;
            end
         end
         mss_pkg::ST_OUTPUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               state_in     = mss_pkg::ST_IDLE;
            end
         end
         default: state_in = mss_pkg::ST_IDLE;
      endcase
   end

   // Hold the result until taken
   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mss_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == mss_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_done_in_run: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> (state_ff == mss_pkg::ST_DIV_RUN))
      else $error("division finished outside the run state");

   a_update_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mss_pkg::ST_UPDATE) |=>
         (state_ff == mss_pkg::ST_DIV_LOAD || state_ff == mss_pkg::ST_OUTPUT))
      else $error("update left to an unexpected state");

   a_div_not_instant: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> !status.div_done)
      else $error("division reported done right after start");

endmodule

// ===== rtl/mss_dpath.sv =====
`timescale 1ns / 1ps

module mss_dpath #(
   parameter int CHANNELS = 5
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mss_pkg::mss_cmd_type                 cmd,
   output mss_pkg::mss_status_type              status,
   input  logic [mss_pkg::CH_W-1:0]             req_channel,
   input  logic signed [mss_pkg::SAMPLE_W-1:0]  req_sample_value,
   input  logic [mss_pkg::STAMP_W-1:0]          req_stamp,
   input  logic                                 csr_write,
   input  logic [mss_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [mss_pkg::CSR_DATA_W-1:0]       csr_data,
   output logic [mss_pkg::CH_W-1:0]             rsp_out_channel,
   output logic signed [mss_pkg::SMALL_W-1:0]   rsp_smallest,
   output logic signed [mss_pkg::SAMPLE_W-1:0]  rsp_largest,
   output logic signed [mss_pkg::MEAN_W-1:0]    rsp_mean_q8,
   output logic [mss_pkg::ENERGY_W-1:0]         rsp_energy_sum,
   output logic [mss_pkg::COUNT_W-1:0]          rsp_sample_count,
   output logic signed [mss_pkg::TIME_W-1:0]    rsp_elapsed,
   output logic                                 rsp_limit_reached
);

   localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CH_W     = mss_pkg::CH_W;
   localparam int SAMPLE_W = mss_pkg::SAMPLE_W;
   localparam int SMALL_W  = mss_pkg::SMALL_W;
   localparam int MEAN_W   = mss_pkg::MEAN_W;
   localparam int ENERGY_W = mss_pkg::ENERGY_W;
   localparam int COUNT_W  = mss_pkg::COUNT_W;
   localparam int TIME_W   = mss_pkg::TIME_W;
   localparam int SUM_W    = mss_pkg::SUM_W;
   localparam int KIND_W   = mss_pkg::KIND_W;
   localparam int N_W      = mss_pkg::DIVIDEND_W;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [SUM_W-1:0]   SUM_MAX   = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic [SUM_W-1:0]   SUM_MIN   = {1'b1, {(SUM_W-1){1'b0}}};
   localparam logic [MEAN_W-1:0]  MEAN_MAX  = {1'b0, {(MEAN_W-1){1'b1}}};
   localparam logic [MEAN_W-1:0]  MEAN_MIN  = {1'b1, {(MEAN_W-1){1'b0}}};

   function automatic logic [SMALL_W-1:0] mag17(input logic [SMALL_W-1:0] x);
      return x[SMALL_W-1] ? SMALL_W'(~x + 1'b1) : x;
   endfunction

   // Configuration registers
   logic [mss_pkg::KINDS_W-1:0] kinds_ff;
   logic [TIME_W-1:0]           limit_ff;

   // Item registers
   logic [CH_W-1:0]     ch_ff;
   logic [SAMPLE_W-1:0] val_ff;
   logic [TIME_W-2:0]   stamp_ff;

   // Per-channel statistics
   logic [SMALL_W-1:0]  min_ff    [CHANNELS];
   logic [SAMPLE_W-1:0] max_ff    [CHANNELS];
   logic [SUM_W-1:0]    sum_ff    [CHANNELS];
   logic [MEAN_W-1:0]   mean_ff   [CHANNELS];
   logic [ENERGY_W-1:0] energy_ff [CHANNELS];

   // Global statistics
   logic [COUNT_W-1:0] count_ff;
   logic [TIME_W-1:0]  origin_ff;
   logic [TIME_W-1:0]  elapsed_ff;

   logic               neg_ff;

   logic [IDX_W-1:0]    idx;
   logic                in_range;
   logic [KIND_W-1:0]   kinds;
   logic                is_stamp;
   logic                has_mean;
   logic                has_energy;
   logic [SMALL_W-1:0]  val_ext;
   logic [SMALL_W-1:0]  val_mag;
   logic [SMALL_W-1:0]  min_mag;
   logic [SMALL_W-1:0]  max_mag;
   logic [SUM_W:0]      sum_wide;
   logic [SUM_W-1:0]    sum_in;
   logic [ENERGY_W:0]   energy_wide;
   logic [ENERGY_W-1:0] energy_in;
   logic [TIME_W-1:0]   elapsed_in;
   logic [SUM_W-1:0]    sum_cur;
   logic [SUM_W-1:0]    sum_abs;
   logic [N_W-1:0]      quotient;
   logic                div_done;
   logic                q_big;
   logic [MEAN_W-1:0]   mean_in;
   logic                limit_in;

   // Take the item
   always_ff @(posedge clock) begin
      if (cmd.take_item) begin
         ch_ff    <= req_channel;
         val_ff   <= req_sample_value;
         stamp_ff <= req_stamp;
      end
   end

   // Write configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         kinds_ff <= '0;
         limit_ff <= '1;
      end else if (csr_write) begin
         unique case (csr_index)
            mss_pkg::REG_CHANNEL_KINDS:  kinds_ff <= csr_data[mss_pkg::KINDS_W-1:0];
            mss_pkg::REG_DURATION_LIMIT: limit_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Decode the item's channel
   assign in_range   = ({1'b0, ch_ff} < (CH_W+1)'(CHANNELS));
   assign idx        = ch_ff[IDX_W-1:0];
   assign kinds      = mss_pkg::kinds_of(kinds_ff, ch_ff);
   assign is_stamp   = |(kinds & mss_pkg::KIND_STAMP);
   assign has_mean   = |(kinds & mss_pkg::KIND_MEAN);
   assign has_energy = |(kinds & mss_pkg::KIND_ENERGY);

   // Magnitudes, saturating sums and elapsed time
   always_comb begin
      val_ext     = {val_ff[SAMPLE_W-1], val_ff};
      val_mag     = mag17(val_ext);
      min_mag     = mag17(min_ff[idx]);
      max_mag     = mag17({max_ff[idx][SAMPLE_W-1], max_ff[idx]});

      sum_wide    = {sum_ff[idx][SUM_W-1], sum_ff[idx]}
                    + {{(SUM_W+1-SAMPLE_W){val_ff[SAMPLE_W-1]}}, val_ff};
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         sum_in = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
      end else begin
         sum_in = sum_wide[SUM_W-1:0];
      end

      energy_wide = {1'b0, energy_ff[idx]} + {{(ENERGY_W+1-SMALL_W){1'b0}}, val_mag};
      energy_in   = energy_wide[ENERGY_W] ? {ENERGY_W{1'b1}} : energy_wide[ENERGY_W-1:0];

      elapsed_in  = {1'b0, stamp_ff} - origin_ff;
   end

   assign status.mean_due = in_range && !is_stamp && has_mean
                            && ((count_ff != '0) || (ch_ff == '0));
   assign status.div_done = div_done;

   // Divider operands: |sum| * 256 over the scan count
   assign sum_cur = sum_ff[idx];
   assign sum_abs = sum_cur[SUM_W-1] ? SUM_W'(~sum_cur + 1'b1) : sum_cur;

   mss_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend ({sum_abs, 8'h00}),
      .divisor  (count_ff),
      .quotient (quotient),
      .done     (div_done)
   );

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         neg_ff <= sum_cur[SUM_W-1];
      end
   end

   // Saturate the quotient to the Q8 range and restore the sign
   always_comb begin
      q_big = |quotient[N_W-1:MEAN_W-1];
      if (neg_ff) begin
         mean_in = q_big ? MEAN_MIN : MEAN_W'(~{1'b0, quotient[MEAN_W-2:0]} + 1'b1);
      end else begin
         mean_in = q_big ? MEAN_MAX : {1'b0, quotient[MEAN_W-2:0]};
      end
   end

   // Update the statistics of the item's channel
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            min_ff[c]    <= mss_pkg::MIN_RESET;
            max_ff[c]    <= '0;
            sum_ff[c]    <= '0;
            mean_ff[c]   <= '0;
            energy_ff[c] <= '0;
         end
         count_ff   <= '0;
         origin_ff  <= '0;
         elapsed_ff <= '0;
      end else begin
         if (cmd.update && in_range) begin
            if ((ch_ff == '0) && (count_ff != COUNT_MAX)) begin
               count_ff <= count_ff + 1'b1;
            end
            if (is_stamp) begin
               elapsed_ff <= elapsed_in;
               if (origin_ff == '0) begin
                  origin_ff <= elapsed_in;
               end
            end else begin
               if (min_mag > val_mag) begin
                  min_ff[idx] <= val_ext;
               end
               if (max_mag < val_mag) begin
                  max_ff[idx] <= val_ff;
               end
               if (has_mean) begin
                  sum_ff[idx] <= sum_in;
               end
               if (has_energy) begin
                  energy_ff[idx] <= energy_in;
               end
            end
         end
         if (cmd.write_mean) begin
            mean_ff[idx] <= mean_in;
         end
      end
   end

   assign limit_in = !limit_ff[TIME_W-1] && (limit_ff != '0)
                     && ($signed(elapsed_ff) >= $signed(limit_ff));

   // Load the output register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_out_channel   <= ch_ff;
         rsp_sample_count  <= count_ff;
         rsp_elapsed       <= elapsed_ff;
         rsp_limit_reached <= limit_in;
         if (in_range) begin
            rsp_smallest   <= min_ff[idx];
            rsp_largest    <= max_ff[idx];
            rsp_mean_q8    <= mean_ff[idx];
            rsp_energy_sum <= energy_ff[idx];
         end else begin
            rsp_smallest   <= mss_pkg::MIN_RESET;
            rsp_largest    <= '0;
            rsp_mean_q8    <= '0;
            rsp_energy_sum <= '0;
         end
      end
   end

endmodule

// ===== rtl/multichannel_sample_statistics.sv =====
`timescale 1ns / 1ps
// An accepted item updates its channel, then, when it updates a mean, runs the bit-serial
// mean divider (56 quotient bits, one per cycle), and is then loaded into the output register;
// one item is in work at a time, and no new item is accepted until its result is loaded.
// A waiting result sits in an output register while the next item is accepted.
// Reset (synchronous, active high) clears all statistics, flags and the duration limit
// (to -1); configuration writes are taken at any time.

module multichannel_sample_statistics #(
   parameter int CHANNELS = 5
) (
   input  logic      clock,
   input  logic      reset,
   mss_req_if.sink   req_bus,
   mss_rsp_if.source rsp_bus,
   mss_csr_if.sink   csr_bus
);

   mss_pkg::mss_cmd_type    cmd;
   mss_pkg::mss_status_type status;

   // Register writes are always taken
   assign csr_bus.ready = 1'b1;

   mss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   mss_dpath #(
      .CHANNELS (CHANNELS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_channel       (req_bus.channel),
      .req_sample_value  (req_bus.sample_value),
      .req_stamp         (req_bus.stamp),
      .csr_write         (csr_bus.valid),
      .csr_index         (csr_bus.index),
      .csr_data          (csr_bus.data),
      .rsp_out_channel   (rsp_bus.out_channel),
      .rsp_smallest      (rsp_bus.smallest),
      .rsp_largest       (rsp_bus.largest),
      .rsp_mean_q8       (rsp_bus.mean_q8),
      .rsp_energy_sum    (rsp_bus.energy_sum),
      .rsp_sample_count  (rsp_bus.sample_count),
      .rsp_elapsed       (rsp_bus.elapsed),
      .rsp_limit_reached (rsp_bus.limit_reached)
   );

endmodule

// ===== verif/multichannel_sample_statistics_tb.sv =====
`timescale 1ns / 1ps

module multichannel_sample_statistics_tb;
   import mss_pkg::*;

   localparam int CHANNELS      = 5;
   localparam int LATENCY       = 64;
   localparam int LIMIT_CYCLES  = 1000000;
   localparam int LONG_HOLD     = 400;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS   = 105;

   // Flags that the package leaves out; they must not change the statistics
   localparam logic [KIND_W-1:0] KIND_MIN      = 5'h02;
   localparam logic [KIND_W-1:0] KIND_MAX      = 5'h08;
   localparam logic [KIND_W-1:0] KIND_DATA_ALL = KIND_ENERGY | KIND_MIN | KIND_MEAN | KIND_MAX;

   // Register indexes with no register behind them
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_B = 2'd3;

   localparam longint SUM_MAX             = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint SUM_MIN             = -SUM_MAX - 1;
   localparam longint MEAN_MAX            = 8388607;
   localparam logic [63:0] MEAN_CLAMP     = 64'd8388608;
   localparam logic [ENERGY_W-1:0] ENERGY_FULL = '1;
   localparam logic [COUNT_W-1:0]  COUNT_FULL  = '1;
   localparam logic [CSR_DATA_W-1:0] LIMIT_OFF      = '1;
   localparam logic [CSR_DATA_W-1:0] LIMIT_MOST_NEG = 64'h8000_0000_0000_0000;
   localparam logic [CSR_DATA_W-1:0] LIMIT_MOST_POS = 64'h7FFF_FFFF_FFFF_FFFF;

   typedef struct {
      logic [CH_W-1:0]            out_channel;
      logic signed [SMALL_W-1:0]  smallest;
      logic signed [SAMPLE_W-1:0] largest;
      logic signed [MEAN_W-1:0]   mean_q8;
      logic [ENERGY_W-1:0]        energy_sum;
      logic [COUNT_W-1:0]         sample_count;
      logic signed [TIME_W-1:0]   elapsed;
      logic                       limit_reached;
   } stats_t;

   // Running per-channel statistics and the results still owed by the block
   class stats_ledger;
      logic [KINDS_W-1:0]       kinds;
      logic signed [TIME_W-1:0] limit;
      int                       min_seen[CHANNELS];
      int                       max_seen[CHANNELS];
      longint                   sum_seen[CHANNELS];
      longint                   mean_seen[CHANNELS];
      logic [ENERGY_W-1:0]      energy_seen[CHANNELS];
      logic [COUNT_W-1:0]       scans;
      logic [TIME_W-1:0]        origin;
      logic [TIME_W-1:0]        span;
      stats_t                   due_stats[$];
      int errors, checked, items, mean_updates, stamps, limit_hits, stray;

      function new();
         for (int c = 0; c < CHANNELS; c++) begin
            min_seen[c]    = int'(MIN_RESET);
            max_seen[c]    = 0;
            sum_seen[c]    = 0;
            mean_seen[c]   = 0;
            energy_seen[c] = '0;
         end
         scans  = '0;
         origin = '0;
         span   = '0;
         kinds  = '0;
         limit  = -1;
         errors = 0;
         checked = 0;
         items = 0;
         mean_updates = 0;
         stamps = 0;
         limit_hits = 0;
         stray = 0;
      endfunction

      function int magnitude(int v);
         return (v < 0) ? -v : v;
      endfunction

      function void set_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            REG_CHANNEL_KINDS:  kinds = data[KINDS_W-1:0];
            REG_DURATION_LIMIT: limit = data;
            default: ;
         endcase
      endfunction

      // Advance the statistics by one accepted item and queue what it should report
      function void note_item(logic [CH_W-1:0] ch, logic signed [SAMPLE_W-1:0] value,
                              logic [STAMP_W-1:0] stamp);
         stats_t            want;
         logic [KIND_W-1:0] group;
         int                v;
         int                vabs;
         longint            s;
         logic              neg;
         logic [63:0]       m;
         logic [63:0]       q;
         logic [ENERGY_W:0] e;
         want.smallest   = MIN_RESET;
         want.largest    = '0;
         want.mean_q8    = '0;
         want.energy_sum = '0;
         items++;
         if (ch < CHANNELS) begin
            group = kinds[KIND_W*ch +: KIND_W];
            if (ch == 0 && scans != COUNT_FULL)
               scans++;
            if ((group & KIND_STAMP) != 0) begin
               // elapsed first, then latch the origin while it is still zero
               span = {1'b0, stamp} - origin;
               if (origin == 0)
                  origin = span;
               stamps++;
            end else begin
               v    = int'(value);
               vabs = magnitude(v);
               if (magnitude(min_seen[ch]) > vabs)
                  min_seen[ch] = v;
               if (magnitude(max_seen[ch]) < vabs)
                  max_seen[ch] = v;
               if ((group & KIND_MEAN) != 0) begin
                  s = sum_seen[ch] + v;
                  if (s > SUM_MAX)
                     s = SUM_MAX;
                  if (s < SUM_MIN)
                     s = SUM_MIN;
                  sum_seen[ch] = s;
                  // hold the mean until a scan has been counted
                  if (scans != 0) begin
                     neg = (s < 0);
                     m   = neg ? -s : s;
                     m   = m << 8;
                     q   = m / {24'd0, scans};
                     if (q > MEAN_CLAMP)
                        q = MEAN_CLAMP;
                     mean_seen[ch] = neg ? -longint'(q) : longint'(q);
                     if (mean_seen[ch] > MEAN_MAX)
                        mean_seen[ch] = MEAN_MAX;
                     mean_updates++;
                  end
               end
               if ((group & KIND_ENERGY) != 0) begin
                  e = {1'b0, energy_seen[ch]} + (ENERGY_W+1)'(vabs);
                  energy_seen[ch] = (e > {1'b0, ENERGY_FULL}) ? ENERGY_FULL : e[ENERGY_W-1:0];
               end
            end
            want.smallest   = SMALL_W'(min_seen[ch]);
            want.largest    = SAMPLE_W'(max_seen[ch]);
            want.mean_q8    = MEAN_W'(mean_seen[ch]);
            want.energy_sum = energy_seen[ch];
         end else begin
            stray++;
         end
         want.out_channel   = ch;
         want.sample_count  = scans;
         want.elapsed       = span;
         want.limit_reached = (limit > 0) && ($signed(span) >= limit);
         if (want.limit_reached)
            limit_hits++;
         due_stats.push_back(want);
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t mismatch in %s: expected %h, got %h", $time, name, want, got);
         end
      endfunction

      // Match one result against the oldest owed one
      function void check_result(stats_t got);
         stats_t want;
         if (due_stats.size() == 0) begin
            errors++;
            $display("%0t result for channel %0d arrived with none due", $time, got.out_channel);
            return;
         end
         want = due_stats.pop_front();
         checked++;
         compare_field("out_channel", want.out_channel, got.out_channel);
         compare_field("smallest", want.smallest, got.smallest);
         compare_field("largest", want.largest, got.largest);
         compare_field("mean_q8", want.mean_q8, got.mean_q8);
         compare_field("energy_sum", want.energy_sum, got.energy_sum);
         compare_field("sample_count", want.sample_count, got.sample_count);
         compare_field("elapsed", want.elapsed, got.elapsed);
         compare_field("limit_reached", want.limit_reached, got.limit_reached);
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset;
   bit                sender_steady;
   bit                sink_steady;
   bit                hold_off_request;
   int                cycle_count;
   int                settings_used;
   logic [STAMP_W-1:0] stamp_clock;
   stats_ledger       ledger = new();

   mss_req_if req_if ();
   mss_rsp_if rsp_if ();
   mss_csr_if csr_if ();

   multichannel_sample_statistics #(
      .CHANNELS(CHANNELS)
   ) uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   always #6 clock = ~clock;

   // Mostly no gap, some short ones, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 93)
         return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] draw_sample();
      logic signed [SAMPLE_W-1:0] v;
      case ($urandom_range(0, 9))
         0:       v = 16'sh8000;
         1:       v = 16'sh7FFF;
         2:       v = SAMPLE_W'($urandom_range(0, 8) - 4);
         default: v = SAMPLE_W'($urandom);
      endcase
      return v;
   endfunction

   function automatic logic [STAMP_W-1:0] rand_stamp();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[STAMP_W-1:0];
   endfunction

   // Offer one item, wait for its handshake, then idle for a random gap, which may be none
   task automatic send_item(logic [CH_W-1:0] ch, logic signed [SAMPLE_W-1:0] value,
                            logic [STAMP_W-1:0] stamp);
      int gap;
      req_if.valid        <= 1'b1;
      req_if.channel      <= ch;
      req_if.sample_value <= value;
      req_if.stamp        <= stamp;
      do @(posedge clock); while (!req_if.ready);
      ledger.note_item(ch, value, stamp);
      gap = sender_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= index;
      csr_if.data  <= data;
      do @(posedge clock); while (!csr_if.ready);
      ledger.set_reg(index, data);
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Drop valid and hold until every owed result has come back
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (ledger.due_stats.size() != 0);
   endtask

   // Watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t run timed out after %0d cycles", $time, cycle_count);
      $display("** multichannel_sample_statistics: FAILED **");
      $finish;
   end

   // Result side: check accepted items, stall at random or on request
   initial begin
      int     stall_left;
      int     hold_left;
      stats_t got;
      stall_left = 0;
      hold_left  = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            got.out_channel   = rsp_if.out_channel;
            got.smallest      = rsp_if.smallest;
            got.largest       = rsp_if.largest;
            got.mean_q8       = rsp_if.mean_q8;
            got.energy_sum    = rsp_if.energy_sum;
            got.sample_count  = rsp_if.sample_count;
            got.elapsed       = rsp_if.elapsed;
            got.limit_reached = rsp_if.limit_reached;
            ledger.check_result(got);
         end
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            stall_left = sink_steady ? 0 : pick_gap();
            if (stall_left > 0) begin
               stall_left--;
               rsp_if.ready <= 1'b0;
            end else begin
               rsp_if.ready <= 1'b1;
            end
         end
      end
   end

   // Stimulus
   initial begin
      int                    zero_weight;
      logic [CH_W-1:0]       ch;
      logic [STAMP_W-1:0]    stamp;
      logic [KIND_W-1:0]     group;
      logic [KINDS_W-1:0]    kinds;
      logic [CSR_DATA_W-1:0] limit_value;

      reset               <= 1'b1;
      req_if.valid        <= 1'b0;
      req_if.channel      <= '0;
      req_if.sample_value <= '0;
      req_if.stamp        <= '0;
      csr_if.valid        <= 1'b0;
      csr_if.index        <= '0;
      csr_if.data         <= '0;
      sender_steady    = 1'b0;
      sink_steady      = 1'b0;
      hold_off_request = 1'b0;
      settings_used    = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: one channel of each kind, limit just past a known elapsed
      write_reg(REG_CHANNEL_KINDS, {39'd0, KIND_MIN | KIND_MAX, KIND_ENERGY, KIND_MEAN,
                                    KIND_STAMP, KIND_DATA_ALL});
      write_reg(REG_DURATION_LIMIT, 64'd1500);
      write_reg(REG_SPARE_A, '1);
      write_reg(REG_SPARE_B, {$urandom, $urandom});
      settings_used++;
      send_item(3'd2, 16'sd100, rand_stamp());        // sum grows, mean held with no scans
      send_item(3'd1, draw_sample(), 63'd0);          // zero stamp leaves the origin unset
      send_item(3'd1, draw_sample(), 63'd1000);       // first nonzero stamp becomes origin
      send_item(3'd0, 16'sh8000, rand_stamp());
      send_item(3'd0, 16'sh7FFF, rand_stamp());
      send_item(3'd3, 16'sh7FFF, rand_stamp());
      send_item(3'd3, -16'sd32767, rand_stamp());     // equal magnitude: no replacement
      send_item(3'd4, 16'sd0, rand_stamp());
      send_item(3'd2, -16'sd5, rand_stamp());
      send_item(3'd2, 16'sd5, rand_stamp());
      send_item(3'd2, 16'sh7FFF, rand_stamp());
      send_item(3'd2, 16'sh7FFF, rand_stamp());
      send_item(3'd2, 16'sh7FFF, rand_stamp());       // mean clips at the top
      send_item(3'd1, draw_sample(), 63'd2600);       // past the limit
      send_item(3'd1, draw_sample(), 63'd2500);       // exactly at the limit
      send_item(3'd1, draw_sample(), 63'd2499);       // just short of it
      send_item(3'd5, draw_sample(), rand_stamp());
      send_item(3'd6, draw_sample(), rand_stamp());
      send_item(3'd7, draw_sample(), rand_stamp());
      send_item(3'd1, draw_sample(), 63'd0);          // elapsed wraps negative
      send_item(3'd1, draw_sample(), 63'h7FFF_FFFF_FFFF_FFFF);
      send_item(3'd0, 16'sd1, rand_stamp());
      wait_drained();

      // Every channel a timestamp channel; channel 0 must still count scans
      write_reg(REG_CHANNEL_KINDS, '1);
      write_reg(REG_DURATION_LIMIT, LIMIT_MOST_POS);
      settings_used++;
      send_item(3'd0, draw_sample(), 63'd3000);
      send_item(3'd3, draw_sample(), 63'd5000);
      wait_drained();
      write_reg(REG_DURATION_LIMIT, '0);
      settings_used++;
      send_item(3'd4, draw_sample(), 63'd7000);
      wait_drained();
      stamp_clock = 63'd8000;

      // Random phases, each with its own register setting
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 0) begin
            kinds = '0;
         end else if (phase == 1) begin
            kinds = {KIND_GROUPS{KIND_DATA_ALL}};
         end else begin
            for (int c = 0; c < KIND_GROUPS; c++) begin
               group = KIND_W'($urandom_range(0, 31));
               if ($urandom_range(0, 2) != 0)
                  group &= ~KIND_STAMP;
               kinds[KIND_W*c +: KIND_W] = group;
            end
         end
         case ($urandom_range(0, 6))
            0:       limit_value = LIMIT_OFF;
            1:       limit_value = '0;
            2:       limit_value = 64'd1;
            3:       limit_value = LIMIT_MOST_NEG;
            4:       limit_value = LIMIT_MOST_POS;
            default: limit_value = {1'b0, stamp_clock} - ledger.origin
                                   + CSR_DATA_W'($urandom_range(1, 4000));
         endcase
         if (phase == 0)
            limit_value = LIMIT_OFF;
         write_reg(REG_CHANNEL_KINDS, {39'd0, kinds});
         write_reg(REG_DURATION_LIMIT, limit_value);
         settings_used++;

         // Phase four fills the block against a held receiver; phase five never idles
         zero_weight   = $urandom_range(2, 40);
         sender_steady = (phase == 4 || phase == 5);
         sink_steady   = (phase == 5);
         if (phase == 4)
            hold_off_request = 1'b1;

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n == PHASE_ITEMS / 2)
               wait_drained();
            if ($urandom_range(0, 99) < 6)
               ch = CH_W'($urandom_range(5, 7));
            else if ($urandom_range(0, 99) < zero_weight)
               ch = 3'd0;
            else
               ch = CH_W'($urandom_range(1, 4));
            if ($urandom_range(0, 9) == 0) begin
               stamp = rand_stamp();
            end else begin
               stamp_clock = stamp_clock + STAMP_W'($urandom_range(1, 300));
               stamp = stamp_clock;
            end
            send_item(ch, draw_sample(), stamp);
         end
         wait_drained();
      end

      // Let any stray result show up before judging
      repeat (LATENCY) @(posedge clock);
      if (ledger.due_stats.size() != 0) begin
         ledger.errors++;
         $display("%0t %0d results never arrived", $time, ledger.due_stats.size());
      end
      $display("Checked %0d results from %0d items over %0d register settings.",
               ledger.checked, ledger.items, settings_used);
      $display("Mean updates %0d, timestamp items %0d (%0d at the limit), unused channels %0d.",
               ledger.mean_updates, ledger.stamps, ledger.limit_hits, ledger.stray);
      if (ledger.errors == 0) begin
         $display("** multichannel_sample_statistics: PASSED **");
      end else begin
         $display("** multichannel_sample_statistics: FAILED **");
      end
      $finish;
   end

endmodule
